// ===== design/dcb_pkg.sv =====
// ----------------------------------------------------------------------------
// dcb_pkg: shared definitions for the display crossfade and blink core
// Command codes, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package dcb_pkg;

  // Command carried in the input tuser field.
  typedef enum logic [1:0] {
    OP_SET     = 2'd0,
    OP_FADE    = 2'd1,
    OP_REFRESH = 2'd2,
    OP_BLINK   = 2'd3
  } dcb_op_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_STEP_TICKS_NORMAL = 2'd0;
  localparam logic [1:0] REG_STEP_TICKS_ANIM   = 2'd1;
  localparam logic [1:0] REG_ANIM_MODE         = 2'd2;
  localparam logic [1:0] REG_BLINK_INTERVAL    = 2'd3;

  localparam int unsigned FIELD_W      = 32;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned TIMER_W      = 16;
  localparam int unsigned STEP_W       = 5;
  localparam int unsigned PRESCALE_W   = 8;

  localparam logic [PRESCALE_W-1:0] BLINK_INTERVAL_RESET = 8'd5;

endpackage

// ===== design/display_crossfade_blink_core.sv =====
// ----------------------------------------------------------------------------
// display_crossfade_blink_core: LED word pattern driver
// Set, crossfade, refresh and blink commands on one input stream; the
// pattern to show on each refresh or blink toggle on the output stream.
// ----------------------------------------------------------------------------
// The core takes one command per clock cycle while s_tready is high and
// updates all of its state in the cycle of the transfer; each result is
// registered. Results pass through a two-entry output register, so the
// input stalls only when two results are waiting to be taken; set and fade
// commands, and blink ticks that do not toggle, give no result. The user
// must write configuration through the plain write port only while the core
// is idle, not enforced by the core; it takes effect for the next command.
module display_crossfade_blink_core
  import dcb_pkg::*;
#(
  parameter int unsigned PATTERN_WIDTH = 32,
  parameter int unsigned FADE_STEPS    = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [63:0]           s_tdata,   // [31:0] new_pattern, [63:32] blink_request
  input  logic [1:0]            s_tuser,   // [1:0] opcode
  // Output stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // [31:0] shown_pattern
  // Configuration write port.
  input  logic                  wr_en,
  input  logic [1:0]            wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  localparam logic [STEP_W-1:0] DITHER_TOP = STEP_W'(FADE_STEPS - 1);

  typedef logic [PATTERN_WIDTH-1:0] pattern_t;

  // Configuration registers.
  logic [TIMER_W-1:0]    step_ticks_normal;
  logic [TIMER_W-1:0]    step_ticks_anim;
  logic                  anim_mode;
  logic [PRESCALE_W-1:0] blink_interval;

  // Display state.
  pattern_t              current_pattern, current_pattern_next;
  pattern_t              previous_pattern, previous_pattern_next;
  pattern_t              blink_bits, blink_bits_next;
  logic [STEP_W-1:0]     dither_counter, dither_counter_next;
  logic [STEP_W-1:0]     fade_step, fade_step_next;
  logic [TIMER_W-1:0]    step_timer, step_timer_next;
  logic [PRESCALE_W-1:0] blink_prescaler, blink_prescaler_next;

  // Output register and skid entry.
  logic                  skid_valid;
  logic [31:0]           skid_data;

  logic                  accept;
  dcb_op_t               op;
  logic [63:0]           pat_ext, req_ext;
  pattern_t              pat, req;
  pattern_t              result;
  logic [63:0]           result_ext;
  logic                  has_result;
  logic [TIMER_W-1:0]    step_reload;
  logic [PRESCALE_W-1:0] prescale_dec;

  assign s_tready    = !skid_valid;
  assign accept      = s_tvalid && s_tready;
  assign op          = dcb_op_t'(s_tuser);
  assign pat_ext     = {32'd0, s_tdata[31:0]};
  assign req_ext     = {32'd0, s_tdata[63:32]};
  assign pat         = pat_ext[PATTERN_WIDTH-1:0];
  assign req         = req_ext[PATTERN_WIDTH-1:0];
  assign step_reload = anim_mode ? step_ticks_anim : step_ticks_normal;
  assign prescale_dec = blink_prescaler - PRESCALE_W'(1);
  assign result_ext  = 64'(result);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ticks_normal <= '0;
      step_ticks_anim   <= '0;
      anim_mode         <= 1'b0;
      blink_interval    <= BLINK_INTERVAL_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_STEP_TICKS_NORMAL: step_ticks_normal <= wr_data[TIMER_W-1:0];
        REG_STEP_TICKS_ANIM:   step_ticks_anim   <= wr_data[TIMER_W-1:0];
        REG_ANIM_MODE:         anim_mode         <= wr_data[0];
        REG_BLINK_INTERVAL:    blink_interval    <= wr_data[PRESCALE_W-1:0];
      endcase
    end
  end

  always_comb begin
    current_pattern_next  = current_pattern;
    previous_pattern_next = previous_pattern;
    blink_bits_next       = blink_bits;
    dither_counter_next   = dither_counter;
    fade_step_next        = fade_step;
    step_timer_next       = step_timer;
    blink_prescaler_next  = blink_prescaler;
    result                = current_pattern;
    has_result            = 1'b0;
    unique case (op)
      OP_SET: begin
        blink_bits_next      = req & pat;
        current_pattern_next = pat;
        fade_step_next       = '0;
      end
      OP_FADE: begin
        blink_bits_next       = '0;
        previous_pattern_next = current_pattern;
        current_pattern_next  = pat;
        fade_step_next        = DITHER_TOP;
        step_timer_next       = step_reload;
        dither_counter_next   = DITHER_TOP;
      end
      OP_REFRESH: begin
        has_result = 1'b1;
        if (fade_step != '0) begin
          result = (dither_counter >= fade_step) ? current_pattern : previous_pattern;
          if (dither_counter != '0) begin
            dither_counter_next = dither_counter - STEP_W'(1);
          end else begin
            // End of a dither round: advance the step timer, and the step
            // itself once the timer has run out.
            dither_counter_next = DITHER_TOP;
            if (step_timer != '0) begin
              step_timer_next = step_timer - TIMER_W'(1);
            end else begin
              step_timer_next = step_reload;
              fade_step_next  = fade_step - STEP_W'(1);
            end
          end
        end
      end
      OP_BLINK: begin
        if (blink_bits != '0 && fade_step == '0) begin
          blink_prescaler_next = prescale_dec;
          if (prescale_dec == '0) begin
            current_pattern_next = current_pattern ^ blink_bits;
            blink_prescaler_next = blink_interval;
            result               = current_pattern ^ blink_bits;
            has_result           = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_pattern  <= '0;
      previous_pattern <= '0;
      blink_bits       <= '0;
      dither_counter   <= '0;
      fade_step        <= '0;
      step_timer       <= '0;
      blink_prescaler  <= BLINK_INTERVAL_RESET;
    end else if (accept) begin
      current_pattern  <= current_pattern_next;
      previous_pattern <= previous_pattern_next;
      blink_bits       <= blink_bits_next;
      dither_counter   <= dither_counter_next;
      fade_step        <= fade_step_next;
      step_timer       <= step_timer_next;
      blink_prescaler  <= blink_prescaler_next;
    end
  end

  // A new result goes to the output register when it is free or being
  // taken, and to the skid entry otherwise. The input is held off while the
  // skid entry is full, so no result arrives while it drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid   <= accept && has_result;
      end
    end else if (accept && has_result) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
      end else if (accept && has_result) begin
        m_tdata <= result_ext[31:0];
      end
    end else if (accept && has_result) begin
      skid_data <= result_ext[31:0];
    end
  end

`ifndef SYNTHESIS
  // The skid entry is only ever filled behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry holds a result while the output register is empty");

  // Blinking is cleared by a fade and cannot be set while one runs.
  a_no_blink_in_fade: assert property (@(posedge clk) disable iff (rst)
    (fade_step != '0) |-> (blink_bits == '0))
    else $error("blink bits set while a fade is running");

  a_fade_start: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_FADE) |=> (fade_step == DITHER_TOP && dither_counter == DITHER_TOP))
    else $error("fade command did not restart the step and dither counter");

  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    (dither_counter <= DITHER_TOP) && (fade_step <= DITHER_TOP))
    else $error("dither counter or fade step beyond the last step");

  // A refresh tick always yields a result; m_tvalid is set once it is accepted.
  a_refresh_result: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_REFRESH) |=> m_tvalid)
    else $error("refresh tick gave no result");
`endif

endmodule
